[rtl/ath_pkg.sv]
// Shared types, constants and lookup functions for the printer-byte to HTML text encoder.
`timescale 1ns / 1ps

package ath_pkg;

  // Input byte codes and ranges.
  localparam logic [7:0] EOL_BYTE      = 8'd155;
  localparam logic [7:0] PRINT_LO      = 8'd32;
  localparam logic [7:0] PRINT_HI      = 8'd122;
  localparam logic [7:0] BACKTICK_BYTE = 8'd96;
  localparam logic [7:0] PUA_BASE_HI   = 8'hE0;

  // Output characters.
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A_MINUS_TEN = 8'h57;

  localparam int SPAN_OPEN_LEN  = 17;
  localparam int SPAN_CLOSE_LEN = 7;
  localparam logic [8*SPAN_OPEN_LEN-1:0]  SPAN_OPEN  = "<span class=\"iv\">";
  localparam logic [8*SPAN_CLOSE_LEN-1:0] SPAN_CLOSE = "</span>";

  // Depth of the job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Index into the fixed strings; wide enough for the open-span text.
  localparam int IDX_W = $clog2(SPAN_OPEN_LEN);

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_OPEN,
    PRE_CLOSE
  } pre_t;

  typedef enum logic [1:0] {
    BODY_CHAR,
    BODY_ENTITY,
    BODY_EOL
  } body_t;

  // One classified byte: optional span prefix, then a body.
  typedef struct packed {
    pre_t        pre;
    body_t       body;
    logic [15:0] val;   // character in the low byte, or entity code point
    logic [1:0]  ndig;  // number of hex digits minus one
  } job_t;

  typedef enum logic [2:0] {
    ST_NEW,
    ST_PRE,
    ST_EHEAD,
    ST_HEX,
    ST_SEMI,
    ST_CHAR,
    ST_CR,
    ST_LF
  } st_t;

  function automatic logic [7:0] open_char(input logic [IDX_W-1:0] i);
    return SPAN_OPEN[8*(SPAN_OPEN_LEN-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] close_char(input logic [IDX_W-1:0] i);
    return SPAN_CLOSE[8*(SPAN_CLOSE_LEN-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (CH_ZERO + {4'h0, d}) : (CH_A_MINUS_TEN + {4'h0, d});
  endfunction

  // Unicode replacement for special glyphs; zero means the byte passes as is.
  function automatic logic [15:0] glyph(input logic [6:0] c);
    logic [15:0] g;
    g = 16'd0;
    case (c)
      7'd0:   g = 16'd9829;
      7'd1:   g = 16'd9500;
      7'd2:   g = 16'd9621;
      7'd3:   g = 16'd9496;
      7'd4:   g = 16'd9508;
      7'd5:   g = 16'd9488;
      7'd6:   g = 16'd9585;
      7'd7:   g = 16'd9586;
      7'd8:   g = 16'd9698;
      7'd9:   g = 16'd9623;
      7'd10:  g = 16'd9699;
      7'd11:  g = 16'd9629;
      7'd12:  g = 16'd9624;
      7'd13:  g = 16'd9620;
      7'd14:  g = 16'd9601;
      7'd15:  g = 16'd9622;
      7'd16:  g = 16'd9827;
      7'd17:  g = 16'd9484;
      7'd18:  g = 16'd9472;
      7'd19:  g = 16'd9532;
      7'd20:  g = 16'd11044;
      7'd21:  g = 16'd9604;
      7'd22:  g = 16'd9615;
      7'd23:  g = 16'd9516;
      7'd24:  g = 16'd9524;
      7'd25:  g = 16'd9612;
      7'd26:  g = 16'd9492;
      7'd27:  g = 16'd8455;
      7'd28:  g = 16'd8593;
      7'd29:  g = 16'd8595;
      7'd30:  g = 16'd8592;
      7'd31:  g = 16'd8594;
      7'd38:  g = 16'd38;
      7'd60:  g = 16'd60;
      7'd62:  g = 16'd62;
      7'd96:  g = 16'd9830;
      7'd123: g = 16'd9824;
      7'd124: g = 16'd9475;
      7'd125: g = 16'd8598;
      7'd126: g = 16'd9658;
      7'd127: g = 16'd9668;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

  // Hex digit count minus one, with no leading zeros.
  function automatic logic [1:0] digits_m1(input logic [15:0] v);
    logic [1:0] n;
    if (v[15:12] != 4'h0) begin
      n = 2'd3;
    end else if (v[11:8] != 4'h0) begin
      n = 2'd2;
    end else if (v[7:4] != 4'h0) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

[rtl/atascii_to_html_text_encoder.sv]
// Top level of the printer-byte to HTML text encoder: front, job queue and character sequencer.
// A beat is written into the job queue; its first character is then registered at the output.
// Throughput: one output character per cycle unless the sink stalls; a byte yields 1 to 25 characters.
// A four-entry job queue lets input beats arrive while earlier bytes are still being expanded.
// Dropped bytes after an end of line are accepted but never queued, so they take no sequencer time.
// Reset (rst, synchronous, active high) clears font mode, span and skip state and the queue.
`timescale 1ns / 1ps

module atascii_to_html_text_encoder (
  input  logic       clk,
  input  logic       rst,
  // Configuration: bit 0 is font_mode.
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // Input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_buffer
  // Output stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // last_of_run
);

  logic          q_full;
  logic          push;
  ath_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  ath_pkg::job_t head_job;

  // The front decides per beat whether the byte is dropped, which span text
  // precedes it and whether its body is a plain character, an entity or CR LF.
  ath_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .q_full      (q_full),
    .in_ready    (s_axis_tready),
    .push        (push),
    .push_job    (push_job)
  );

  // Classified jobs wait here so that both sides can stall independently.
  ath_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The sequencer spells each job out one character per beat and marks the
  // final character of the run with tlast.
  ath_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

[rtl/ath_front.sv]
// Front end: accepts input beats, tracks span and skip state, and classifies each byte into a job.
`timescale 1ns / 1ps

module ath_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output ath_pkg::job_t push_job
);

  logic font_mode;
  logic inverse_on;
  logic inverse_on_next;
  logic skip_rest;
  logic skip_rest_next;
  logic accept;
  logic printable;
  logic [15:0] g;
  logic [15:0] ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && !skip_rest;

  assign printable = (in_byte >= ath_pkg::PRINT_LO) && (in_byte <= ath_pkg::PRINT_HI) &&
                     (in_byte != ath_pkg::BACKTICK_BYTE);

  always_comb begin
    inverse_on_next = inverse_on;
    skip_rest_next  = skip_rest;
    push_job.pre    = ath_pkg::PRE_NONE;
    push_job.body   = ath_pkg::BODY_CHAR;
    push_job.val    = {8'h00, in_byte};
    g               = 16'd0;
    ent             = 16'd0;
    if (skip_rest) begin
      if (in_last) begin
        skip_rest_next = 1'b0;
      end
    end else if (in_byte == ath_pkg::EOL_BYTE) begin
      if (inverse_on) begin
        push_job.pre    = ath_pkg::PRE_CLOSE;
        inverse_on_next = 1'b0;
      end
      push_job.body  = ath_pkg::BODY_EOL;
      skip_rest_next = !in_last;
    end else if (font_mode) begin
      if (printable) begin
        g = ath_pkg::glyph(in_byte[6:0]);
        if (g != 16'd0) begin
          push_job.body = ath_pkg::BODY_ENTITY;
          ent           = g;
        end
      end else begin
        push_job.body = ath_pkg::BODY_ENTITY;
        ent           = {ath_pkg::PUA_BASE_HI, in_byte};
      end
    end else begin
      if (in_byte[7]) begin
        if (!inverse_on) begin
          push_job.pre    = ath_pkg::PRE_OPEN;
          inverse_on_next = 1'b1;
        end
      end else if (inverse_on) begin
        push_job.pre    = ath_pkg::PRE_CLOSE;
        inverse_on_next = 1'b0;
      end
      push_job.val = {9'h000, in_byte[6:0]};
      g = ath_pkg::glyph(in_byte[6:0]);
      if (g != 16'd0) begin
        push_job.body = ath_pkg::BODY_ENTITY;
        ent           = g;
      end
    end
    if (push_job.body == ath_pkg::BODY_ENTITY) begin
      push_job.val = ent;
    end
    push_job.ndig = ath_pkg::digits_m1(push_job.val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      font_mode  <= 1'b0;
      inverse_on <= 1'b0;
      skip_rest  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        font_mode <= cfg_wr_data;
      end
      if (accept) begin
        inverse_on <= inverse_on_next;
        skip_rest  <= skip_rest_next;
      end
    end
  end

endmodule

[rtl/ath_queue.sv]
// Short job queue that decouples the classifying front from the character sequencer.
`timescale 1ns / 1ps

module ath_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ath_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output ath_pkg::job_t head_job
);

  ath_pkg::job_t               slots [ath_pkg::QDEPTH];
  logic [ath_pkg::QPTR_W-1:0]  wptr;
  logic [ath_pkg::QPTR_W-1:0]  rptr;
  logic [ath_pkg::QCNT_W-1:0]  count;

  assign full       = (count == ath_pkg::QCNT_W'(ath_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= ath_pkg::QCNT_W'(ath_pkg::QDEPTH))
    else $error("job queue count out of range");
`endif

endmodule

[rtl/ath_back.sv]
// Back end: walks each job one character per cycle, unless the output stalls, into a registered output stage.
`timescale 1ns / 1ps

module ath_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  ath_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last
);

  ath_pkg::st_t               st;
  ath_pkg::st_t               st_next;
  ath_pkg::st_t               cur;
  ath_pkg::st_t               body_st;
  logic [ath_pkg::IDX_W-1:0]  idx;
  logic [ath_pkg::IDX_W-1:0]  idx_next;
  logic                       step;
  logic [7:0]                 ch_c;
  logic                       last_c;
  logic                       pre_end;

  assign step = head_valid && (!out_valid || out_ready);

  always_comb begin
    unique case (head_job.body)
      ath_pkg::BODY_ENTITY: body_st = ath_pkg::ST_EHEAD;
      ath_pkg::BODY_EOL:    body_st = ath_pkg::ST_CR;
      default:              body_st = ath_pkg::ST_CHAR;
    endcase
  end

  // A fresh job starts at its prefix, or directly at its body.
  always_comb begin
    if (st == ath_pkg::ST_NEW) begin
      cur = (head_job.pre == ath_pkg::PRE_NONE) ? body_st : ath_pkg::ST_PRE;
    end else begin
      cur = st;
    end
  end

  assign pre_end = (head_job.pre == ath_pkg::PRE_OPEN) ?
                   (idx == ath_pkg::IDX_W'(ath_pkg::SPAN_OPEN_LEN - 1)) :
                   (idx == ath_pkg::IDX_W'(ath_pkg::SPAN_CLOSE_LEN - 1));

  // Next state and index.
  always_comb begin
    st_next  = st;
    idx_next = idx;
    pop      = 1'b0;
    if (step) begin
      unique case (cur) inside
        ath_pkg::ST_PRE: begin
          if (pre_end) begin
            st_next  = body_st;
            idx_next = '0;
          end else begin
            st_next  = ath_pkg::ST_PRE;
            idx_next = idx + 1'b1;
          end
        end
        ath_pkg::ST_EHEAD: begin
          if (idx == ath_pkg::IDX_W'(2)) begin
            st_next  = ath_pkg::ST_HEX;
            idx_next = ath_pkg::IDX_W'(head_job.ndig);
          end else begin
            st_next  = ath_pkg::ST_EHEAD;
            idx_next = idx + 1'b1;
          end
        end
        ath_pkg::ST_HEX: begin
          if (idx == '0) begin
            st_next = ath_pkg::ST_SEMI;
          end else begin
            st_next  = ath_pkg::ST_HEX;
            idx_next = idx - 1'b1;
          end
        end
        ath_pkg::ST_CR: begin
          st_next = ath_pkg::ST_LF;
        end
        ath_pkg::ST_SEMI, ath_pkg::ST_CHAR, ath_pkg::ST_LF: begin
          st_next  = ath_pkg::ST_NEW;
          idx_next = '0;
          pop      = 1'b1;
        end
        default: begin
          st_next = ath_pkg::ST_NEW;
        end
      endcase
    end
  end

  // Character for the current step.
  always_comb begin
    ch_c   = head_job.val[7:0];
    last_c = 1'b0;
    unique case (cur)
      ath_pkg::ST_PRE: begin
        ch_c = (head_job.pre == ath_pkg::PRE_OPEN) ? ath_pkg::open_char(idx) :
                                                     ath_pkg::close_char(idx);
      end
      ath_pkg::ST_EHEAD: begin
        case (idx[1:0])
          2'd0:    ch_c = ath_pkg::CH_AMP;
          2'd1:    ch_c = ath_pkg::CH_HASH;
          default: ch_c = ath_pkg::CH_X;
        endcase
      end
      ath_pkg::ST_HEX: begin
        ch_c = ath_pkg::hex_char(head_job.val[{idx[1:0], 2'b00} +: 4]);
      end
      ath_pkg::ST_SEMI: begin
        ch_c   = ath_pkg::CH_SEMI;
        last_c = 1'b1;
      end
      ath_pkg::ST_CHAR: begin
        last_c = 1'b1;
      end
      ath_pkg::ST_CR: begin
        ch_c = ath_pkg::CH_CR;
      end
      ath_pkg::ST_LF: begin
        ch_c   = ath_pkg::CH_LF;
        last_c = 1'b1;
      end
      default: begin
        ch_c = head_job.val[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ath_pkg::ST_NEW;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_char <= ch_c;
      out_last <= last_c;
    end
  end

endmodule

[tb/tb_atascii_to_html_text_encoder.sv]
// Self-checking testbench for the printer-byte to HTML text encoder.
`timescale 1ns / 1ps

// Expected character stream: models the encoder's span and skip state and keeps
// the characters that each accepted byte must produce, oldest first.
class html_text_scoreboard;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } html_char_t;

  localparam int unsigned PRIVATE_BASE = 32'hE000;
  localparam logic [7:0]  INVERSE_BIT  = 8'd128;
  localparam logic [7:0]  FONT_LO      = 8'd32;
  localparam logic [7:0]  FONT_HI      = 8'd122;
  localparam logic [7:0]  GRAVE        = 8'd96;

  logic       font_mode;
  logic       inverse_on;
  logic       skip_rest;
  html_char_t expected_chars[$];
  html_char_t run_chars[$];
  int         errors;
  int         chars_checked;
  int         bytes_taken;
  int         bytes_dropped;

  function new();
    font_mode     = 1'b0;
    inverse_on    = 1'b0;
    skip_rest     = 1'b0;
    errors        = 0;
    chars_checked = 0;
    bytes_taken   = 0;
    bytes_dropped = 0;
  endfunction

  function void set_font_mode(logic v);
    font_mode = v;
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  // Unicode code point for the special glyphs; zero means the byte passes as is.
  function int unsigned glyph_point(logic [6:0] c);
    int unsigned p;
    p = 0;
    case (c)
      7'd0:   p = 9829;   7'd1:   p = 9500;   7'd2:   p = 9621;   7'd3:   p = 9496;
      7'd4:   p = 9508;   7'd5:   p = 9488;   7'd6:   p = 9585;   7'd7:   p = 9586;
      7'd8:   p = 9698;   7'd9:   p = 9623;   7'd10:  p = 9699;   7'd11:  p = 9629;
      7'd12:  p = 9624;   7'd13:  p = 9620;   7'd14:  p = 9601;   7'd15:  p = 9622;
      7'd16:  p = 9827;   7'd17:  p = 9484;   7'd18:  p = 9472;   7'd19:  p = 9532;
      7'd20:  p = 11044;  7'd21:  p = 9604;   7'd22:  p = 9615;   7'd23:  p = 9516;
      7'd24:  p = 9524;   7'd25:  p = 9612;   7'd26:  p = 9492;   7'd27:  p = 8455;
      7'd28:  p = 8593;   7'd29:  p = 8595;   7'd30:  p = 8592;   7'd31:  p = 8594;
      7'd38:  p = 38;     7'd60:  p = 60;     7'd62:  p = 62;     7'd96:  p = 9830;
      7'd123: p = 9824;   7'd124: p = 9475;   7'd125: p = 8598;   7'd126: p = 9658;
      7'd127: p = 9668;
      default: p = 0;
    endcase
    return p;
  endfunction

  function void add_char(logic [7:0] ch);
    html_char_t e;
    e.ch   = ch;
    e.last = 1'b0;
    run_chars.push_back(e);
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // Hex entity in lowercase with no leading zeros.
  function void add_entity(int unsigned v);
    string       hexdig;
    bit          started;
    int unsigned d;
    hexdig  = "0123456789abcdef";
    started = 1'b0;
    add_text("&#x");
    for (int sh = 28; sh >= 0; sh -= 4) begin
      d = (v >> sh) & 4'hF;
      if (d != 0 || started || sh == 0) begin
        add_char(hexdig[d]);
        started = 1'b1;
      end
    end
    add_char(";");
  endfunction

  function void add_glyph_or_char(logic [7:0] c);
    int unsigned g;
    g = glyph_point(c[6:0]);
    if (g != 0) add_entity(g);
    else add_char(c);
  endfunction

  // Notes one accepted input beat and returns how many characters it must yield.
  function int take_byte(logic [7:0] b, logic eob);
    logic [7:0] c;
    html_char_t e;
    c = b;
    bytes_taken++;
    run_chars.delete();
    if (skip_rest) begin
      if (eob) skip_rest = 1'b0;
      bytes_dropped++;
      return 0;
    end
    if (c == ath_pkg::EOL_BYTE) begin
      if (inverse_on) begin
        inverse_on = 1'b0;
        add_text("</span>");
      end
      add_char(ath_pkg::CH_CR);
      add_char(ath_pkg::CH_LF);
      skip_rest = !eob;
    end else if (font_mode) begin
      if (c >= FONT_LO && c <= FONT_HI && c != GRAVE) add_glyph_or_char(c);
      else add_entity(PRIVATE_BASE + c);
    end else begin
      if (c >= INVERSE_BIT) begin
        if (!inverse_on) begin
          inverse_on = 1'b1;
          add_text("<span class=\"iv\">");
        end
        c = c - INVERSE_BIT;
      end else if (inverse_on) begin
        inverse_on = 1'b0;
        add_text("</span>");
      end
      add_glyph_or_char(c);
    end
    for (int i = 0; i < run_chars.size(); i++) begin
      e      = run_chars[i];
      e.last = (i == run_chars.size() - 1);
      expected_chars.push_back(e);
    end
    return run_chars.size();
  endfunction

  // Compares one output beat with the oldest expected character.
  function void match_char(logic [7:0] ch, logic last);
    html_char_t e;
    if (expected_chars.size() == 0) begin
      errors++;
      $display("%0t: unexpected character, expected none, actual char=%02h last=%0b",
               $time, ch, last);
      return;
    end
    e = expected_chars.pop_front();
    chars_checked++;
    if (e.ch !== ch) begin
      errors++;
      $display("%0t: out_char mismatch, expected %02h, actual %02h", $time, e.ch, ch);
    end
    if (e.last !== last) begin
      errors++;
      $display("%0t: last_of_run mismatch, expected %0b, actual %0b", $time, e.last, last);
    end
  endfunction

endclass

module tb_atascii_to_html_text_encoder;

  // Generous bound: well over every byte expanding to 25 characters, each one
  // held up by the longest sink stall, plus source gaps and phase pauses.
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   SETTLE_WAIT  = 8;
  localparam int   TAIL_WAIT    = 20;
  localparam int   PHASE_ITEMS  = 16;
  localparam logic FONT_PLAIN   = 1'b0;
  localparam logic FONT_PRIVATE = 1'b1;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tlast;   // end_of_buffer
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;   // [7:0] out_char
  logic       m_axis_tlast;   // last_of_run

  html_text_scoreboard sb;

  // Idle controls: random gaps on the byte source and stalls on the sink.
  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold = 0;
  int cycle_count = 0;
  int runs_plain;
  int runs_font;

  atascii_to_html_text_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run-length guard. A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Output side: check every accepted character beat, then decide whether the
  // sink stalls next cycle. Stalls start at random and come in bursts of random length.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.match_char(m_axis_tdata, m_axis_tlast);
    end
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      sink_hold     <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Presents one byte and waits for its beat. Called right after a rising
  // edge; tvalid stays high afterwards so back-to-back beats need no bubble.
  task automatic push_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    do @(posedge clk); while (!s_axis_tready);
    if (sb.take_byte(b, eob) > 0) begin
      if (sb.font_mode) runs_font++;
      else runs_plain++;
    end
  endtask

  // Holds the source until every expected character has come out, then lets
  // the block settle so it is idle before anything else happens.
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Register write; issued only while the block is idle, after reset or after drain_output.
  task automatic write_font_mode(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_font_mode(v);
  endtask

  // Byte mix weighted toward the interesting classes: end of line, control
  // glyphs with and without the inverse bit, the escaped characters and the
  // table entries at the top of the range.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = ath_pkg::EOL_BYTE;
      1: b = {$urandom_range(0, 1) == 1, 2'b00, 5'($urandom_range(0, 31))};
      2: begin
        case ($urandom_range(0, 4))
          0: b = 8'd38;
          1: b = 8'd60;
          2: b = 8'd62;
          3: b = 8'd96;
          default: b = 8'($urandom_range(123, 127));
        endcase
        b[7] = 1'($urandom_range(0, 1));
      end
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // One random phase at a given mode. Most traffic is whole record buffers
  // (a run of bytes closed by end_of_buffer, sometimes with an end of line in
  // the middle so the tail is dropped); the rest is stray single beats.
  task automatic random_phase(input logic mode, input int target);
    int         start_runs;
    int         len;
    logic [7:0] b;
    drain_output();
    write_font_mode(mode);
    start_runs = runs_plain + runs_font;
    while (runs_plain + runs_font - start_runs < target) begin
      if ($urandom_range(0, 7) == 0) begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          b = pick_byte();
          push_byte(b, i == len - 1);
        end
      end
    end
  endtask

  initial begin
    sb            = new();
    runs_plain    = 0;
    runs_font     = 0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, plain mode: table glyphs, the escaped characters, a normal
    // letter, spans opening and closing, and end of line inside a span.
    write_font_mode(1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd38, 1'b0);
    push_byte(8'd60, 1'b0);
    push_byte(8'd65, 1'b0);
    push_byte(8'd96, 1'b0);
    push_byte(8'd128, 1'b0);
    push_byte(8'd200, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd20, 1'b0);
    push_byte(8'd65, 1'b0);
    push_byte(8'd128, 1'b0);
    // End of line closes the span, then the rest of the buffer is dropped.
    push_byte(ath_pkg::EOL_BYTE, 1'b0);
    push_byte(8'd66, 1'b0);
    push_byte(8'd67, 1'b1);
    // End of line as the last byte of its buffer does not start skipping.
    push_byte(ath_pkg::EOL_BYTE, 1'b1);
    // Leave a span open across the switch to font mode.
    push_byte(8'd200, 1'b1);

    // Directed, font mode: the edges of the pass-through range, the grave
    // accent, control and high bytes, escapes, and the span left open until
    // the end of line finally closes it.
    drain_output();
    write_font_mode(1'b1);
    push_byte(8'd32, 1'b0);
    push_byte(8'd122, 1'b0);
    push_byte(8'd123, 1'b0);
    push_byte(8'd96, 1'b0);
    push_byte(8'd31, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd62, 1'b0);
    push_byte(ath_pkg::EOL_BYTE, 1'b1);

    // Random part with idling on both sides, switching modes between phases.
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    random_phase(FONT_PLAIN, PHASE_ITEMS);
    random_phase(FONT_PRIVATE, PHASE_ITEMS);
    random_phase(1'($urandom_range(0, 1)), PHASE_ITEMS);
    random_phase(FONT_PLAIN, PHASE_ITEMS);

    // Final stretch at full rate on both sides.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    random_phase(FONT_PRIVATE, PHASE_ITEMS);

    drain_output();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d bytes (%0d dropped after end of line); %0d produced text in plain mode,",
             sb.bytes_taken, sb.bytes_dropped, runs_plain);
    $display("%0d in font mode; %0d output characters compared.", runs_font, sb.chars_checked);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ath_pkg.sv
rtl/ath_front.sv
rtl/ath_queue.sv
rtl/ath_back.sv
rtl/atascii_to_html_text_encoder.sv
tb/tb_atascii_to_html_text_encoder.sv
